// ===== sv/scoped_namespace_binding_table_defines.svh =====
// assertion macros for the scoped namespace binding table checker
// used by snbt_check, no other dependencies
`ifndef SCOPED_NAMESPACE_BINDING_TABLE_DEFINES_SVH
`define SCOPED_NAMESPACE_BINDING_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SNBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SNBT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/snbt_pkg.sv =====
// package for the scoped namespace binding table
// field widths, command, status and register codes, map write bundle; no dependencies
`default_nettype none
package snbt_pkg;
    localparam int KEY_W = 10;
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;
    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DECLARE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOK_P  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOK_N  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_POP_ZERO = 3'd1;
    localparam logic [ST_W-1:0] ST_REBOUND  = 3'd2;
    localparam logic [ST_W-1:0] ST_LOG_FULL = 3'd3;
    localparam logic [ST_W-1:0] ST_TOO_DEEP = 3'd4;

    localparam logic REG_XMLNS_NS  = 1'b0;
    localparam logic REG_XMLNS_PFX = 1'b1;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] data;
    } t_map_wr;
endpackage
`default_nettype wire

// ===== sv/snbt_map.sv =====
// one map of the binding table: synchronous ram, one read and one write port
// depends on snbt_pkg
`default_nettype none
module snbt_map #(
    parameter int DEPTH = 1024
) (
    input  wire                        i_clk,
    input  wire  [snbt_pkg::KEY_W-1:0] i_rd_key,
    output logic [snbt_pkg::KEY_W-1:0] o_rd_data,
    input  snbt_pkg::t_map_wr          i_wr
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [snbt_pkg::KEY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.key[AW-1:0]] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_key[AW-1:0]];
    end
endmodule
`default_nettype wire

// ===== sv/scoped_namespace_binding_table.sv =====
// scoped namespace binding table: prefix and namespace maps with undo log
// depends on snbt_pkg and snbt_map
//
// channel   dir  bits  contents
// s_axis    in   24    command, prefix_key, namespace_id, overwrite
// m_axis    out  32    found_namespace, found_prefix, status, scope_level
// cfg       in   10    xmlns_namespace_id (0), xmlns_prefix_key (1)
//
// after reset the maps are cleared, one entry a cycle, for the larger map depth
// with s_axis tready low
// one word at a time: push and lookups pass S_RDMAP and S_FIN; declare adds an
// S_SR_RD/S_SR_CK pair per log entry checked in the search and, unless the search
// finds the binding, S_LOG; pop adds an S_PP_RD/S_PP_CK pair per entry undone
// a stalled result holds in the output register; the next word is still taken
`default_nettype none
module scoped_namespace_binding_table #(
    parameter int PREFIX_COUNT    = 1024,
    parameter int NAMESPACE_COUNT = 1024,
    parameter int UNDO_DEPTH      = 256,
    parameter int MAX_LEVEL       = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // command, prefix_key, namespace_id, overwrite
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // found_namespace, found_prefix, status, scope_level
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire  [9:0]  i_cfg_wdata
);
    localparam int KW   = snbt_pkg::KEY_W;
    localparam int PD   = (PREFIX_COUNT < 1024) ? PREFIX_COUNT : 1024;
    localparam int ND   = (NAMESPACE_COUNT < 1024) ? NAMESPACE_COUNT : 1024;
    localparam int MD   = (PD > ND) ? PD : ND;
    localparam int LW   = $clog2(MAX_LEVEL + 1);
    localparam int CW   = $clog2(UNDO_DEPTH + 1);
    localparam int LA   = $clog2(UNDO_DEPTH);
    localparam int EW   = LW + 4 * KW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDMAP = 4'd2;
    localparam logic [3:0] S_SR_RD = 4'd3;
    localparam logic [3:0] S_SR_CK = 4'd4;
    localparam logic [3:0] S_LOG   = 4'd5;
    localparam logic [3:0] S_PP_RD = 4'd6;
    localparam logic [3:0] S_PP_CK = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]    r_state;
    logic [KW-1:0] r_clr;
    logic [KW-1:0] r_xns, r_xpfx;
    logic [2:0]    r_cmd;
    logic [KW-1:0] r_p, r_n;
    logic          r_ovw;
    logic [KW-1:0] r_pval, r_nval;
    logic [LW-1:0] r_nest;
    logic [CW-1:0] r_cnt, r_idx;
    logic [KW-1:0] r_fns, r_fpx;
    logic [2:0]    r_st;

    logic [KW-1:0] pm_rd, nm_rd;
    snbt_pkg::t_map_wr pm_wr, nm_wr;

    logic [EW-1:0] r_log [UNDO_DEPTH];
    logic [EW-1:0] r_log_q;
    logic [LA-1:0] log_ra;
    logic          log_we;
    logic [EW-1:0] log_wd;

    logic [LW-1:0] e_lvl;
    logic [KW-1:0] e_p, e_n, e_pp, e_pn;
    logic [LW+7:0] lvl_ext;

    function automatic logic p_ok(input logic [KW-1:0] k);
        return {22'd0, k} < 32'(PREFIX_COUNT);
    endfunction

    function automatic logic n_ok(input logic [KW-1:0] k);
        return {22'd0, k} < 32'(NAMESPACE_COUNT);
    endfunction

    assign {e_lvl, e_p, e_n, e_pp, e_pn} = r_log_q;
    assign s_axis_tready = (r_state == S_IDLE);
    assign lvl_ext = {8'd0, r_nest};

    snbt_map #(.DEPTH(PD)) u_pmap (
        .i_clk    (i_clk),
        .i_rd_key (s_axis_tdata[12:3]),
        .o_rd_data(pm_rd),
        .i_wr     (pm_wr)
    );

    snbt_map #(.DEPTH(ND)) u_nmap (
        .i_clk    (i_clk),
        .i_rd_key (s_axis_tdata[22:13]),
        .o_rd_data(nm_rd),
        .i_wr     (nm_wr)
    );

    // map and log write ports, log read address
    always_comb begin
        pm_wr  = '0;
        nm_wr  = '0;
        log_we = 1'b0;
        log_wd = {r_nest, r_p, r_n, r_nval, r_pval};
        log_ra = (r_state == S_PP_RD) ? LA'(r_cnt - 1'b1) : LA'(r_idx - 1'b1);
        unique case (r_state)
            S_CLEAR: begin
                pm_wr = '{en: p_ok(r_clr), key: r_clr, data: '0};
                nm_wr = '{en: n_ok(r_clr), key: r_clr, data: '0};
            end
            S_SR_CK: begin
                if (e_lvl == r_nest && e_p != r_p && e_n == r_n) begin
                    pm_wr = '{en: p_ok(r_p), key: r_p, data: r_n};
                    nm_wr = '{en: n_ok(r_n), key: r_n, data: r_p};
                end
            end
            S_LOG: begin
                if (r_cnt < CW'(UNDO_DEPTH)) begin
                    log_we = 1'b1;
                    pm_wr  = '{en: p_ok(r_p), key: r_p, data: r_n};
                    nm_wr  = '{en: n_ok(r_n), key: r_n, data: r_p};
                end
            end
            S_PP_CK: begin
                if (e_lvl == r_nest) begin
                    pm_wr = '{en: p_ok(e_p), key: e_p, data: e_pn};
                    nm_wr = '{en: n_ok(e_n), key: e_n, data: e_pp};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (log_we) begin
            r_log[r_cnt[LA-1:0]] <= log_wd;
        end
        r_log_q <= r_log[log_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_xns         <= KW'(1);
            r_xpfx        <= KW'(1);
            r_nest        <= LW'(1);
            r_cnt         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == snbt_pkg::REG_XMLNS_NS) begin
                    r_xns <= i_cfg_wdata;
                end else begin
                    r_xpfx <= i_cfg_wdata;
                end
            end
            if (r_state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == KW'(MD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tdata[2:0];
                        r_p     <= s_axis_tdata[12:3];
                        r_n     <= s_axis_tdata[22:13];
                        r_ovw   <= s_axis_tdata[23];
                        r_fns   <= '0;
                        r_fpx   <= '0;
                        r_st    <= snbt_pkg::ST_OK;
                        r_state <= S_RDMAP;
                    end
                end
                S_RDMAP: begin
                    r_pval  <= p_ok(r_p) ? pm_rd : '0;
                    r_nval  <= n_ok(r_n) ? nm_rd : '0;
                    r_state <= S_FIN;
                    case (r_cmd)
                        snbt_pkg::CMD_PUSH: begin
                            if ({{(32-LW){1'b0}}, r_nest} >= 32'(MAX_LEVEL)) begin
                                r_st <= snbt_pkg::ST_TOO_DEEP;
                            end else begin
                                r_nest <= r_nest + 1'b1;
                            end
                        end
                        snbt_pkg::CMD_POP: begin
                            if (r_nest == '0) begin
                                r_st <= snbt_pkg::ST_POP_ZERO;
                            end else begin
                                r_state <= S_PP_RD;
                            end
                        end
                        snbt_pkg::CMD_DECLARE: begin
                            r_idx <= r_cnt;
                            if (!r_ovw && p_ok(r_p) && pm_rd != '0) begin
                                r_state <= S_SR_RD;
                            end else begin
                                r_state <= S_LOG;
                            end
                        end
                        snbt_pkg::CMD_LOOK_P: begin
                            r_fns <= p_ok(r_p) ? pm_rd : '0;
                        end
                        snbt_pkg::CMD_LOOK_N: begin
                            r_fpx <= (r_n == r_xns) ? r_xpfx : (n_ok(r_n) ? nm_rd : '0);
                        end
                        default: begin
                        end
                    endcase
                end
                S_SR_RD: begin
                    r_state <= (r_idx == '0) ? S_LOG : S_SR_CK;
                end
                S_SR_CK: begin
                    if (e_lvl != r_nest) begin
                        r_state <= S_LOG;
                    end else if (e_p == r_p) begin
                        if (e_n != r_n) begin
                            r_st <= snbt_pkg::ST_REBOUND;
                        end
                        r_state <= S_FIN;
                    end else if (e_n == r_n) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SR_RD;
                    end
                end
                S_LOG: begin
                    if (r_cnt < CW'(UNDO_DEPTH)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_st <= snbt_pkg::ST_LOG_FULL;
                    end
                    r_state <= S_FIN;
                end
                S_PP_RD: begin
                    if (r_cnt == '0) begin
                        r_nest  <= r_nest - 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_PP_CK;
                    end
                end
                S_PP_CK: begin
                    if (e_lvl == r_nest) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_PP_RD;
                    end else begin
                        r_nest  <= r_nest - 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tdata  <= {1'b0, lvl_ext[7:0], r_st, r_fpx, r_fns};
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/snbt_check.sv =====
// port-level checker for the scoped namespace binding table, bound to the top
// depends on scoped_namespace_binding_table_defines.svh
`default_nettype none
`include "scoped_namespace_binding_table_defines.svh"
module snbt_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);
    `SNBT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
    `SNBT_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")
    `SNBT_ASSERT_IMP(a_clear, $past(!i_rst_n), !s_axis_tready, "word taken during map clear")
    `SNBT_ASSERT_IMP(a_status, m_axis_tvalid, m_axis_tdata[22:20] <= 3'd4, "status code out of range")
endmodule

bind scoped_namespace_binding_table snbt_check u_snbt_check (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for scoped_namespace_binding_table
// streams commands with random gaps and stalls, predicts every result word
// depends on snbt_pkg and the block rtl
`default_nettype none
module testbench;
    localparam int MAP_N   = 1024;
    localparam int LOG_N   = 256;
    localparam int LVL_MAX = 255;
    localparam int N_RAND  = 176;

    typedef struct packed {
        logic [7:0] level;
        logic [2:0] status;
        logic [9:0] found_pfx;
        logic [9:0] found_ns;
    } t_answer;

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] pfx;
        logic [9:0] ns;
        logic       ovw;
    } t_cmd;

    typedef struct {
        logic [2:0] cmd;
        logic [9:0] pfx;
        logic [9:0] ns;
        logic       ovw;
        logic       typed;
        logic [2:0] status;
        logic [7:0] level;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;

    scoped_namespace_binding_table dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [9:0] pfx_to_ns [MAP_N];
    logic [9:0] ns_to_pfx [MAP_N];
    logic [7:0] log_lvl [LOG_N];
    logic [9:0] log_pfx [LOG_N];
    logic [9:0] log_ns [LOG_N];
    logic [9:0] log_old_pfx [LOG_N];
    logic [9:0] log_old_ns [LOG_N];
    int         log_cnt;
    int         cur_lvl;
    logic [9:0] xmlns_ns_id;
    logic [9:0] xmlns_pfx;

    t_answer    pending_answers[$];
    int         errors = 0;
    int         answers_seen = 0;
    int         stall_mode = 0;
    logic       long_hold = 1'b0;

    function automatic logic [2:0] bind_prefix(logic [9:0] p, logic [9:0] n, logic ovw);
        int i;
        if (!ovw && pfx_to_ns[p] != 0) begin
            for (i = log_cnt; i > 0; i--) begin
                if (log_lvl[i-1] != cur_lvl) break;
                if (log_pfx[i-1] == p) begin
                    if (log_ns[i-1] == n) return snbt_pkg::ST_OK;
                    return snbt_pkg::ST_REBOUND;
                end
                if (log_ns[i-1] == n) begin
                    ns_to_pfx[n] = p;
                    pfx_to_ns[p] = n;
                    return snbt_pkg::ST_OK;
                end
            end
        end
        if (log_cnt >= LOG_N) return snbt_pkg::ST_LOG_FULL;
        log_lvl[log_cnt] = 8'(cur_lvl);
        log_pfx[log_cnt] = p;
        log_ns[log_cnt] = n;
        log_old_pfx[log_cnt] = ns_to_pfx[n];
        log_old_ns[log_cnt] = pfx_to_ns[p];
        log_cnt++;
        ns_to_pfx[n] = p;
        pfx_to_ns[p] = n;
        return snbt_pkg::ST_OK;
    endfunction

    function automatic t_answer resolve(t_cmd c);
        t_answer a;
        a = '0;
        case (c.cmd)
            snbt_pkg::CMD_PUSH: begin
                if (cur_lvl >= LVL_MAX) a.status = snbt_pkg::ST_TOO_DEEP;
                else cur_lvl++;
            end
            snbt_pkg::CMD_POP: begin
                if (cur_lvl == 0) a.status = snbt_pkg::ST_POP_ZERO;
                else begin
                    while (log_cnt > 0 && log_lvl[log_cnt-1] == cur_lvl) begin
                        ns_to_pfx[log_ns[log_cnt-1]] = log_old_pfx[log_cnt-1];
                        pfx_to_ns[log_pfx[log_cnt-1]] = log_old_ns[log_cnt-1];
                        log_cnt--;
                    end
                    cur_lvl--;
                end
            end
            snbt_pkg::CMD_DECLARE: a.status = bind_prefix(c.pfx, c.ns, c.ovw);
            snbt_pkg::CMD_LOOK_P: a.found_ns = pfx_to_ns[c.pfx];
            snbt_pkg::CMD_LOOK_N:
                a.found_pfx = (c.ns == xmlns_ns_id) ? xmlns_pfx : ns_to_pfx[c.ns];
            default: ;
        endcase
        a.level = cur_lvl[7:0];
        return a;
    endfunction

    task automatic send_word(t_cmd c);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (stall_mode == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {c.ovw, c.ns, c.pfx, c.cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(resolve(c));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == snbt_pkg::REG_XMLNS_NS) xmlns_ns_id = val;
        else xmlns_pfx = val;
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // random traffic, undefined command codes included: mostly a small key pool so bindings collide
    function automatic t_cmd random_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(0, 99);
        c.pfx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 12));
        c.ns = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 12));
        c.ovw = ($urandom_range(0, 4) == 0);
        if (r < 15) c.cmd = snbt_pkg::CMD_PUSH;
        else if (r < 28) c.cmd = snbt_pkg::CMD_POP;
        else if (r < 60) c.cmd = snbt_pkg::CMD_DECLARE;
        else if (r < 78) c.cmd = snbt_pkg::CMD_LOOK_P;
        else if (r < 96) c.cmd = snbt_pkg::CMD_LOOK_N;
        else c.cmd = 3'($urandom_range(5, 7));
        return c;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[30:0];
            answers_seen++;
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
            end else begin
                want = pending_answers.pop_front();
                if (got.found_ns !== want.found_ns || got.found_pfx !== want.found_pfx ||
                        got.status !== want.status || got.level !== want.level) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch ns %0d/%0d pfx %0d/%0d st %0d/%0d lvl %0d/%0d",
                            want.found_ns, got.found_ns, want.found_pfx, got.found_pfx,
                            want.status, got.status, want.level, got.level);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (long_hold) m_axis_tready <= 1'b0;
        else if (stall_mode == 0) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 29) == 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic hold_receiver;
        long_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        long_hold = 1'b0;
    endtask

    initial begin
        #8000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_cmd c;
        t_answer a;
        int i;
        int k;
        for (i = 0; i < MAP_N; i++) begin
            pfx_to_ns[i] = '0;
            ns_to_pfx[i] = '0;
        end
        log_cnt = 0;
        cur_lvl = 1;
        xmlns_ns_id = 10'd1;
        xmlns_pfx = 10'd1;

        // directed rows: typed status/level where obvious
        rows.push_back('{snbt_pkg::CMD_LOOK_P, 10'd5, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd1});
        rows.push_back('{snbt_pkg::CMD_LOOK_N, 10'd0, 10'd1, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd1});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd5, 10'd7, 1'b0, 1'b1, snbt_pkg::ST_OK,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd5, 10'd7, 1'b0, 1'b1, snbt_pkg::ST_OK,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd5, 10'd9, 1'b0, 1'b1, snbt_pkg::ST_REBOUND,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd6, 10'd7, 1'b0, 1'b0, snbt_pkg::ST_OK,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd1023, 10'd1023, 1'b1, 1'b0,
                         snbt_pkg::ST_OK, 8'd1});
        rows.push_back('{snbt_pkg::CMD_LOOK_P, 10'd1023, 10'd0, 1'b0, 1'b0, snbt_pkg::ST_OK,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_LOOK_N, 10'd0, 10'd1023, 1'b0, 1'b0, snbt_pkg::ST_OK,
                         8'd1});
        rows.push_back('{snbt_pkg::CMD_PUSH, 10'd0, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd2});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd5, 10'd3, 1'b0, 1'b0, snbt_pkg::ST_OK,
                         8'd2});
        rows.push_back('{snbt_pkg::CMD_DECLARE, 10'd5, 10'd4, 1'b1, 1'b0, snbt_pkg::ST_OK,
                         8'd2});
        rows.push_back('{snbt_pkg::CMD_LOOK_P, 10'd5, 10'd0, 1'b0, 1'b0, snbt_pkg::ST_OK, 8'd2});
        rows.push_back('{snbt_pkg::CMD_POP, 10'd0, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd1});
        rows.push_back('{snbt_pkg::CMD_LOOK_P, 10'd5, 10'd0, 1'b0, 1'b0, snbt_pkg::ST_OK, 8'd1});
        rows.push_back('{snbt_pkg::CMD_POP, 10'd0, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd0});
        rows.push_back('{snbt_pkg::CMD_POP, 10'd0, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_POP_ZERO,
                         8'd0});
        rows.push_back('{3'd5, 10'h3ff, 10'h3ff, 1'b1, 1'b1, snbt_pkg::ST_OK, 8'd0});
        rows.push_back('{3'd7, 10'h2aa, 10'h155, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd0});
        rows.push_back('{snbt_pkg::CMD_PUSH, 10'd0, 10'd0, 1'b0, 1'b1, snbt_pkg::ST_OK, 8'd1});

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            c = '{rows[i].cmd, rows[i].pfx, rows[i].ns, rows[i].ovw};
            send_word(c);
            if (rows[i].typed) begin
                a = pending_answers[$];
                if (a.status !== rows[i].status || a.level !== rows[i].level) begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d st %0d/%0d lvl %0d/%0d", i,
                            rows[i].status, a.status, rows[i].level, a.level);
                end
            end
        end
        drain();

        // push to the top and past it
        stall_mode = 1;
        for (i = 0; i < 256; i++) send_word('{snbt_pkg::CMD_PUSH, 10'd0, 10'd0, 1'b0});
        // fill the undo log past full
        for (i = 0; i < 260; i++)
            send_word('{snbt_pkg::CMD_DECLARE, 10'(i + 1), 10'(i + 2), 1'b1});
        send_word('{snbt_pkg::CMD_LOOK_N, 10'd0, 10'd9, 1'b0});
        fork
            hold_receiver();
            for (k = 0; k < 6; k++)
                send_word('{snbt_pkg::CMD_LOOK_P, 10'(k + 1), 10'd0, 1'b0});
        join
        for (i = 0; i < 4; i++) send_word('{snbt_pkg::CMD_POP, 10'd0, 10'd0, 1'b0});
        drain();

        for (k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    write_reg(snbt_pkg::REG_XMLNS_NS, 10'd0);
                    write_reg(snbt_pkg::REG_XMLNS_PFX, 10'd1023);
                end
                1: begin
                    write_reg(snbt_pkg::REG_XMLNS_NS, 10'd1023);
                    write_reg(snbt_pkg::REG_XMLNS_PFX, 10'd0);
                end
                2: begin
                    write_reg(snbt_pkg::REG_XMLNS_NS, 10'd4);
                    write_reg(snbt_pkg::REG_XMLNS_PFX, 10'd9);
                end
                default: begin
                    write_reg(snbt_pkg::REG_XMLNS_NS, 10'($urandom));
                    write_reg(snbt_pkg::REG_XMLNS_PFX, 10'($urandom));
                end
            endcase
            stall_mode = (k != 1);
            for (i = 0; i < 4; i++) send_word('{snbt_pkg::CMD_PUSH, 10'd0, 10'd0, 1'b0});
            for (i = 0; i < N_RAND / 4; i++) begin
                c = random_cmd();
                if (c.cmd == snbt_pkg::CMD_LOOK_N && $urandom_range(0, 5) == 0)
                    c.ns = xmlns_ns_id;
                send_word(c);
            end
            drain();
        end

        if (errors == 0 && pending_answers.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
